[rtl/assert_macros.svh]
// assertion macros shared by the checker
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`define VGA_ASSERT_IMPL(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error("assertion failed");
`define VGA_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("assertion failed");
`endif

[rtl/vga_pkg.sv]
// ----------------------------------------------------------------------------
// vga_pkg
// types, constants and command structs of the voxel grid accumulator
// ----------------------------------------------------------------------------
package vga_pkg;
  localparam int unsigned TableSize  = 4096;
  localparam int unsigned SlotW      = $clog2(TableSize);
  localparam int unsigned ProbeLimit = 16;
  localparam int unsigned ProbeW     = $clog2(ProbeLimit + 1);
  localparam int unsigned CfgW       = 23;
  localparam int unsigned CfgIdxW    = 3;
  // accumulator record: cnt 32, sums 3x64, colour 3x40, sq 64
  localparam int unsigned RecW       = 32 + 3 * 64 + 3 * 40 + 64;
  localparam int unsigned KeyW       = 72;

  localparam logic [2:0] CfgNth  = 3'd0;
  localparam logic [2:0] CfgMinR = 3'd1;
  localparam logic [2:0] CfgMaxR = 3'd2;
  localparam logic [2:0] CfgVox  = 3'd3;
  localparam logic [2:0] CfgInv  = 3'd4;
  localparam logic [2:0] CfgMaxV = 3'd5;

  localparam logic [1:0] KindPoint = 2'd0;
  localparam logic [1:0] KindFrame = 2'd1;
  localparam logic [1:0] KindRead  = 2'd2;
  localparam logic [1:0] KindNone  = 2'd3;

  localparam logic [2:0] StDecim = 3'd0;
  localparam logic [2:0] StNonFin = 3'd1;
  localparam logic [2:0] StRange = 3'd2;
  localparam logic [2:0] StUpd   = 3'd3;
  localparam logic [2:0] StIns   = 3'd4;
  localparam logic [2:0] StFull  = 3'd5;
  localparam logic [2:0] StRead  = 3'd6;

  typedef struct packed {
    logic [1:0]         kind;
    logic               point_finite;
    logic signed [23:0] local_x;
    logic signed [23:0] local_y;
    logic signed [23:0] local_z;
    logic signed [31:0] world_x;
    logic signed [31:0] world_y;
    logic signed [31:0] world_z;
    logic [7:0]         red;
    logic [7:0]         green;
    logic [7:0]         blue;
    logic [11:0]        read_slot;
  } in_item_t;

  typedef struct packed {
    logic [2:0]         status;
    logic [11:0]        slot;
    logic [31:0]        sample_count;
    logic signed [63:0] total_x;
    logic signed [63:0] total_y;
    logic signed [63:0] total_z;
    logic [39:0]        total_red;
    logic [39:0]        total_green;
    logic [39:0]        total_blue;
    logic [63:0]        total_sq_offset;
  } out_item_t;

  typedef struct packed {
    logic [11:0] nth;
    logic [22:0] min_r;
    logic [22:0] max_r;
    logic [15:0] vox;
    logic [16:0] inv;
    logic [12:0] max_v;
  } cfg_t;

  // controller to datapath
  typedef struct packed {
    logic       clr;      // clear one table entry after reset
    logic       load;     // capture input beat
    logic       calc1;    // products: squares, key mults
    logic       calc2;    // range sum, keys
    logic       calc3;    // hash, centre offsets
    logic       calc4;    // offset squares
    logic       rd;       // issue table read at probe slot
    logic       step;     // advance probe slot
    logic       wr_new;   // write fresh record with this point
    logic       wr_upd;   // write updated record
    logic       res_empty;
    logic       res_slot;
    logic       use_rd_slot;
    logic [2:0] status;
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic       clr_done;
    logic [1:0] kind;
    logic       finite;
    logic       keep;
    logic       in_range;
    logic       used;
    logic       key_match;
    logic       full;
  } sts_t;
endpackage

[rtl/vga_ram.sv]
// ----------------------------------------------------------------------------
// vga_ram
// generic single port ram with registered read
// ----------------------------------------------------------------------------
module vga_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] addr_i,
  input  logic [Width-1:0]         wdata_i,
  output logic [Width-1:0]         rdata_o
);
  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
    rdata_o <= mem_q[addr_i];
  end
endmodule

[rtl/vga_datapath.sv]
// ----------------------------------------------------------------------------
// vga_datapath
// range gate, key and hash arithmetic, probe and accumulator table
// ----------------------------------------------------------------------------
module vga_datapath (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  vga_pkg::in_item_t   in_i,
  input  vga_pkg::cfg_t       cfg_i,
  input  vga_pkg::cmd_t       cmd_i,
  output vga_pkg::sts_t       sts_o,
  output vga_pkg::out_item_t  res_o
);
  import vga_pkg::*;

  in_item_t            it_q;
  logic [11:0]         cnt_q;
  logic [12:0]         nvox_q;
  logic [SlotW-1:0]    clr_q;
  logic                keep_q;
  logic [47:0]         sqx_q, sqy_q, sqz_q;
  logic [45:0]         min2_q, max2_q;
  logic signed [48:0]  px_q, py_q, pz_q;
  logic                rng_q;
  logic signed [32:0]  kfx_q, kfy_q, kfz_q;
  logic [SlotW-1:0]    hash_q, slot_q;
  logic [30:0]         ax_q, ay_q, az_q;
  logic [63:0]         sq_q;
  logic [61:0]         ox_q, oy_q, oz_q;
  logic [RecW-1:0]     rec_rd, rec_wd;
  logic [KeyW-1:0]     key_cur;
  logic [KeyW:0]       key_rd, key_wd;
  logic                we, key_we;
  logic [SlotW-1:0]    addr;
  logic [11:0]         n_eff, cnt_nx;
  logic [31:0]         rc;
  logic [63:0]         rx, ry, rz, rs;
  logic [39:0]         rr, rg, rb;
  out_item_t           res_q;

  function automatic logic signed [32:0] fkey(input logic signed [48:0] p);
    fkey = 33'(p >>> 16);
  endfunction

  function automatic logic [30:0] cofs(input logic signed [31:0] w,
                                       input logic signed [32:0] k,
                                       input logic [15:0] v);
    logic signed [51:0] d;
    logic [51:0] a;
    d = 52'(w) * 2 - (52'(k) * 2 + 52'sd1) * $signed({36'd0, v});
    a = d[51] ? 52'(-d) : d;
    cofs = (a > 52'h7FFFFFFF) ? 31'h7FFFFFFF : a[30:0];
  endfunction

  assign n_eff  = (cfg_i.nth == 12'd0) ? 12'd1 : cfg_i.nth;

  always_comb begin
    logic [11:0] c;
    c = (it_q.kind == KindFrame) ? 12'd0 : cnt_q;
    cnt_nx = (13'(c) + 13'd1 >= 13'(n_eff)) ? 12'd0 : c + 12'd1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      nvox_q <= '0;
      clr_q  <= '0;
    end else begin
      if (cmd_i.calc1 && (it_q.kind == KindPoint || it_q.kind == KindFrame)) begin
        cnt_q <= cnt_nx;
      end
      if (cmd_i.wr_new) begin
        nvox_q <= nvox_q + 13'd1;
      end
      if (cmd_i.clr) begin
        clr_q <= clr_q + SlotW'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) it_q <= in_i;
    if (cmd_i.calc1) begin
      keep_q <= (it_q.kind == KindFrame) ? 1'b1 : (cnt_q == 12'd0);
      sqx_q  <= 48'(it_q.local_x * it_q.local_x);
      sqy_q  <= 48'(it_q.local_y * it_q.local_y);
      sqz_q  <= 48'(it_q.local_z * it_q.local_z);
      min2_q <= 46'(cfg_i.min_r * cfg_i.min_r);
      max2_q <= 46'(cfg_i.max_r * cfg_i.max_r);
      px_q   <= 49'(it_q.world_x) * $signed({32'd0, cfg_i.inv});
      py_q   <= 49'(it_q.world_y) * $signed({32'd0, cfg_i.inv});
      pz_q   <= 49'(it_q.world_z) * $signed({32'd0, cfg_i.inv});
    end
    if (cmd_i.calc2) begin
      rng_q <= !(50'(sqx_q) + 50'(sqy_q) + 50'(sqz_q) < 50'(min2_q) ||
                 50'(sqx_q) + 50'(sqy_q) + 50'(sqz_q) > 50'(max2_q));
      kfx_q <= fkey(px_q);
      kfy_q <= fkey(py_q);
      kfz_q <= fkey(pz_q);
    end
    if (cmd_i.calc3) begin
      hash_q <= SlotW'((32'(kfx_q[23:0]) * 32'd73856093) ^
                       (32'(kfy_q[23:0]) * 32'd19349663) ^
                       (32'(kfz_q[23:0]) * 32'd83492791));
      ax_q <= cofs(it_q.world_x, kfx_q, cfg_i.vox);
      ay_q <= cofs(it_q.world_y, kfy_q, cfg_i.vox);
      az_q <= cofs(it_q.world_z, kfz_q, cfg_i.vox);
    end
    if (cmd_i.calc4) begin
      ox_q <= ax_q * ax_q;
      oy_q <= ay_q * ay_q;
      oz_q <= az_q * az_q;
      slot_q <= hash_q;
    end else if (cmd_i.step) begin
      slot_q <= slot_q + SlotW'(1);
    end else if (cmd_i.use_rd_slot) begin
      slot_q <= SlotW'(it_q.read_slot);
    end
    if (cmd_i.rd) sq_q <= (64'(ox_q) + 64'(oy_q) + 64'(oz_q)) >> 2;
  end

  // key table entry: used flag above the three packed keys
  assign key_cur = {kfx_q[23:0], kfy_q[23:0], kfz_q[23:0]};
  assign key_wd  = cmd_i.clr ? '0 : {1'b1, key_cur};
  assign key_we  = cmd_i.wr_new || cmd_i.clr;
  assign addr    = cmd_i.clr ? clr_q : slot_q;
  assign we      = cmd_i.wr_new || cmd_i.wr_upd;
  assign {rc, rx, ry, rz, rr, rg, rb, rs} = cmd_i.wr_new ? '0 : rec_rd;

  assign rec_wd = {rc + 32'd1,
                   rx + 64'(it_q.world_x), ry + 64'(it_q.world_y),
                   rz + 64'(it_q.world_z),
                   rr + 40'(it_q.red), rg + 40'(it_q.green), rb + 40'(it_q.blue),
                   rs + sq_q};

  vga_ram #(.Width(RecW), .Depth(TableSize)) u_rec (
    .clk_i, .we_i(we), .addr_i(addr), .wdata_i(rec_wd), .rdata_o(rec_rd)
  );
  vga_ram #(.Width(KeyW + 1), .Depth(TableSize)) u_key (
    .clk_i, .we_i(key_we), .addr_i(addr), .wdata_i(key_wd), .rdata_o(key_rd)
  );

  always_ff @(posedge clk_i) begin
    if (cmd_i.res_empty) begin
      res_q <= {cmd_i.status, (cmd_i.status == StRead) ? it_q.read_slot : 12'd0,
                RecW'(0)};
    end else if (cmd_i.res_slot) begin
      res_q <= {cmd_i.status, 12'(slot_q), (cmd_i.status == StRead) ? rec_rd : rec_wd};
    end
  end

  assign res_o            = res_q;
  assign sts_o.clr_done   = (clr_q == '1);
  assign sts_o.kind       = it_q.kind;
  assign sts_o.finite     = it_q.point_finite;
  assign sts_o.keep       = keep_q;
  assign sts_o.in_range   = rng_q;
  assign sts_o.used       = key_rd[KeyW];
  assign sts_o.key_match  = (key_rd[KeyW-1:0] == key_cur);
  assign sts_o.full       = (nvox_q >= cfg_i.max_v);
endmodule

[rtl/vga_ctrl.sv]
// ----------------------------------------------------------------------------
// vga_ctrl
// sequencer for table clear, gating, hash probe, accumulator update and readout
// ----------------------------------------------------------------------------
module vga_ctrl (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_ready_o,
  output logic          out_valid_o,
  input  logic          out_ready_i,
  input  vga_pkg::sts_t sts_i,
  output vga_pkg::cmd_t cmd_o
);
  import vga_pkg::*;

  localparam logic [3:0] SIdle = 4'd0, SC1 = 4'd1, SC2 = 4'd2, SC3 = 4'd3,
                         SC4 = 4'd4, SRd = 4'd5, SChk = 4'd6, SRdRead = 4'd7,
                         SRdOut = 4'd8, SOut = 4'd9, SGate = 4'd10, SWait = 4'd11,
                         SClr = 4'd12;

  logic [3:0]        st_q, st_d;
  logic [ProbeW-1:0] pr_q, pr_d;
  logic              ov_q, ov_d;

  assign in_ready_o  = (st_q == SIdle) && !ov_q;
  assign out_valid_o = ov_q;

  always_comb begin
    st_d  = st_q;
    pr_d  = pr_q;
    ov_d  = ov_q && !out_ready_i;
    cmd_o = '0;
    unique case (st_q)
      SClr: begin
        cmd_o.clr = 1'b1;
        if (sts_i.clr_done) st_d = SIdle;
      end
      SIdle: begin
        if (in_valid_i && in_ready_o) begin
          cmd_o.load = 1'b1;
          st_d = SC1;
        end
      end
      SC1: begin
        if (sts_i.kind == KindNone) begin
          st_d = SIdle;
        end else if (sts_i.kind == KindRead) begin
          cmd_o.use_rd_slot = 1'b1;
          st_d = SRdRead;
        end else begin
          cmd_o.calc1 = 1'b1;
          st_d = SGate;
        end
      end
      SGate: begin
        cmd_o.calc2 = 1'b1;
        st_d = SC2;
      end
      SC2: begin
        cmd_o.status = !sts_i.keep ? StDecim : !sts_i.finite ? StNonFin : StRange;
        if (!sts_i.keep || !sts_i.finite || !sts_i.in_range) begin
          cmd_o.res_empty = 1'b1;
          st_d = SOut;
        end else begin
          cmd_o.calc3 = 1'b1;
          st_d = SC3;
        end
      end
      SC3: begin
        cmd_o.calc4 = 1'b1;
        pr_d = '0;
        st_d = SRd;
      end
      SC4: begin
        cmd_o.step = 1'b1;
        st_d = SRd;
      end
      SRd: begin
        cmd_o.rd = 1'b1;
        st_d = SChk;
      end
      SChk: begin
        if (!sts_i.used) begin
          if (sts_i.full) begin
            cmd_o.status = StFull;
            cmd_o.res_empty = 1'b1;
          end else begin
            cmd_o.status = StIns;
            cmd_o.wr_new = 1'b1;
            cmd_o.res_slot = 1'b1;
          end
          st_d = SOut;
        end else if (sts_i.key_match) begin
          cmd_o.status = StUpd;
          cmd_o.wr_upd = 1'b1;
          cmd_o.res_slot = 1'b1;
          st_d = SOut;
        end else if (pr_q == ProbeW'(ProbeLimit - 1)) begin
          cmd_o.status = StFull;
          cmd_o.res_empty = 1'b1;
          st_d = SOut;
        end else begin
          pr_d = pr_q + ProbeW'(1);
          st_d = SC4;
        end
      end
      SRdRead: st_d = SRdOut;
      SRdOut: begin
        cmd_o.status = StRead;
        if (sts_i.used) cmd_o.res_slot = 1'b1;
        else cmd_o.res_empty = 1'b1;
        st_d = SOut;
      end
      SOut: begin
        ov_d = 1'b1;
        st_d = SWait;
      end
      SWait: st_d = SIdle;
      default: st_d = SIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= SClr;
      pr_q <= '0;
      ov_q <= 1'b0;
    end else begin
      st_q <= st_d;
      pr_q <= pr_d;
      ov_q <= ov_d;
    end
  end
endmodule

[rtl/voxel_grid_accumulator.sv]
// ----------------------------------------------------------------------------
// voxel_grid_accumulator
// decimating, range gated voxel hash accumulator for coloured points
// ----------------------------------------------------------------------------
// One item at a time. After reset every slot table entry is cleared,
// during which no beat is taken. An accumulated point makes up to 16
// hash probes of the single ported slot table, each a read and a key
// compare. Results sit in an output register; the next beat is taken
// once the result has gone out.
module voxel_grid_accumulator (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         cfg_we_i,
  input  logic [vga_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  logic [vga_pkg::CfgW-1:0]     cfg_data_i,
  input  logic                         in_valid_i,
  output logic                         in_ready_o,
  input  vga_pkg::in_item_t            in_data_i,
  output logic                         out_valid_o,
  input  logic                         out_ready_i,
  output vga_pkg::out_item_t           out_data_o
);
  import vga_pkg::*;

  cfg_t cfg_q;
  cmd_t cmd;
  sts_t sts;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '{nth: 12'd12, min_r: 23'd307, max_r: 23'd8192, vox: 16'd102,
                 inv: 17'd643, max_v: 13'd4096};
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CfgNth:  cfg_q.nth   <= cfg_data_i[11:0];
        CfgMinR: cfg_q.min_r <= cfg_data_i;
        CfgMaxR: cfg_q.max_r <= cfg_data_i;
        CfgVox:  cfg_q.vox   <= cfg_data_i[15:0];
        CfgInv:  cfg_q.inv   <= cfg_data_i[16:0];
        CfgMaxV: cfg_q.max_v <= cfg_data_i[12:0];
        default: ;
      endcase
    end
  end

  vga_ctrl u_ctrl (
    .clk_i, .rst_ni, .in_valid_i, .in_ready_o, .out_valid_o, .out_ready_i,
    .sts_i(sts), .cmd_o(cmd)
  );

  vga_datapath u_dp (
    .clk_i, .rst_ni, .in_i(in_data_i), .cfg_i(cfg_q), .cmd_i(cmd),
    .sts_o(sts), .res_o(out_data_o)
  );
endmodule

[rtl/vga_checker.sv]
// ----------------------------------------------------------------------------
// vga_checker
// port level checks of the voxel grid accumulator
// ----------------------------------------------------------------------------
`include "assert_macros.svh"
module vga_checker (
  input logic               clk_i,
  input logic               rst_ni,
  input logic               in_valid_i,
  input logic               in_ready_o,
  input logic               out_valid_o,
  input logic               out_ready_i,
  input vga_pkg::out_item_t out_data_o
);
  import vga_pkg::*;

  `VGA_ASSERT_NEXT(a_out_hold, clk_i, rst_ni, out_valid_o && !out_ready_i, out_valid_o && $stable(out_data_o))
  `VGA_ASSERT_IMPL(a_no_take_busy, clk_i, rst_ni, out_valid_o, !in_ready_o)
  `VGA_ASSERT_IMPL(a_status_ok, clk_i, rst_ni, out_valid_o, out_data_o.status <= StRead)
  `VGA_ASSERT_IMPL(a_empty_zero, clk_i, rst_ni, out_valid_o && (out_data_o.status == StDecim || out_data_o.status == StFull), out_data_o.sample_count == 32'd0)
endmodule

bind voxel_grid_accumulator vga_checker u_chk (.*);

[tb/tb_voxel_grid_accumulator.sv]
// ----------------------------------------------------------------------------
// tb_voxel_grid_accumulator
// self-checking bench for the voxel grid accumulator: directed and random
// beats under several register settings and idle patterns; a mirror of the
// voxel hash table predicts every result beat, which is compared per field
// ----------------------------------------------------------------------------
module tb_voxel_grid_accumulator;
  import vga_pkg::*;

  class voxel_mirror;
    cfg_t        regs;
    bit          used [TableSize];
    logic [23:0] key_x [TableSize];
    logic [23:0] key_y [TableSize];
    logic [23:0] key_z [TableSize];
    logic [63:0] sum_x [TableSize];
    logic [63:0] sum_y [TableSize];
    logic [63:0] sum_z [TableSize];
    logic [39:0] sum_r [TableSize];
    logic [39:0] sum_g [TableSize];
    logic [39:0] sum_b [TableSize];
    logic [63:0] sum_sq [TableSize];
    logic [31:0] cnt [TableSize];
    int          voxels;
    int          pt_count;
    int          errors;
    int          touched [$];
    out_item_t   pending [$];

    function new();
      regs = '{nth: 12'd12, min_r: 23'd307, max_r: 23'd8192, vox: 16'd102,
               inv: 17'd643, max_v: 13'd4096};
      voxels = 0;
      pt_count = 0;
      errors = 0;
    endfunction

    function void queue_res(out_item_t r);
      pending = {pending, r};
    endfunction

    function void set_reg(logic [2:0] idx, logic [22:0] val);
      case (idx)
        CfgNth:  regs.nth   = val[11:0];
        CfgMinR: regs.min_r = val[22:0];
        CfgMaxR: regs.max_r = val[22:0];
        CfgVox:  regs.vox   = val[15:0];
        CfgInv:  regs.inv   = val[16:0];
        CfgMaxV: regs.max_v = val[12:0];
        default: ;
      endcase
    endfunction

    function logic [63:0] half_sq(longint w, longint k);
      longint d;
      logic [63:0] a;
      d = 2 * w - (2 * k + 1) * longint'(regs.vox);
      a = (d < 0) ? -d : d;
      if (a > 64'h7FFF_FFFF) a = 64'h7FFF_FFFF;
      return a * a;
    endfunction

    function void fill(ref out_item_t r, input int s);
      r.sample_count    = cnt[s];
      r.total_x         = sum_x[s];
      r.total_y         = sum_y[s];
      r.total_z         = sum_z[s];
      r.total_red       = sum_r[s];
      r.total_green     = sum_g[s];
      r.total_blue      = sum_b[s];
      r.total_sq_offset = sum_sq[s];
    endfunction

    function void note_beat(in_item_t b);
      out_item_t   r;
      int          n, cur, s, t;
      bit          found, empty;
      longint      lx, ly, lz, wx, wy, wz, fx, fy, fz;
      logic [63:0] rsq, lo, hi, sq;
      logic [23:0] kx, ky, kz;
      logic [31:0] hv;
      r = '0;
      if (b.kind == KindNone) return;
      if (b.kind == KindRead) begin
        s = int'(b.read_slot);
        r.status = StRead;
        r.slot = b.read_slot;
        if (used[s]) fill(r, s);
        queue_res(r);
        return;
      end
      if (b.kind == KindFrame) pt_count = 0;
      n = (regs.nth == 0) ? 1 : int'(regs.nth);
      cur = pt_count;
      pt_count = (cur + 1 >= n) ? 0 : cur + 1;
      if (cur != 0) begin
        r.status = StDecim;
        queue_res(r);
        return;
      end
      if (!b.point_finite) begin
        r.status = StNonFin;
        queue_res(r);
        return;
      end
      lx = longint'(b.local_x);
      ly = longint'(b.local_y);
      lz = longint'(b.local_z);
      rsq = lx * lx + ly * ly + lz * lz;
      lo = longint'(regs.min_r) * longint'(regs.min_r);
      hi = longint'(regs.max_r) * longint'(regs.max_r);
      if (rsq < lo || rsq > hi) begin
        r.status = StRange;
        queue_res(r);
        return;
      end
      wx = longint'(b.world_x);
      wy = longint'(b.world_y);
      wz = longint'(b.world_z);
      fx = (wx * longint'(regs.inv)) >>> 16;
      fy = (wy * longint'(regs.inv)) >>> 16;
      fz = (wz * longint'(regs.inv)) >>> 16;
      kx = fx[23:0];
      ky = fy[23:0];
      kz = fz[23:0];
      hv = ({8'd0, kx} * 32'd73856093) ^ ({8'd0, ky} * 32'd19349663) ^
           ({8'd0, kz} * 32'd83492791);
      found = 0;
      empty = 0;
      s = 0;
      for (int i = 0; i < ProbeLimit; i++) begin
        t = int'((32'(hv[11:0]) + 32'(i)) % TableSize);
        if (!used[t]) begin
          empty = 1;
          s = t;
          break;
        end
        if (key_x[t] == kx && key_y[t] == ky && key_z[t] == kz) begin
          found = 1;
          s = t;
          break;
        end
      end
      if (!found) begin
        if (!empty || voxels >= int'(regs.max_v)) begin
          r.status = StFull;
          queue_res(r);
          return;
        end
        used[s] = 1;
        key_x[s] = kx;
        key_y[s] = ky;
        key_z[s] = kz;
        sum_x[s] = 0;
        sum_y[s] = 0;
        sum_z[s] = 0;
        sum_r[s] = 0;
        sum_g[s] = 0;
        sum_b[s] = 0;
        sum_sq[s] = 0;
        cnt[s] = 0;
        voxels++;
        touched = {touched, s};
      end
      sum_x[s] += wx;
      sum_y[s] += wy;
      sum_z[s] += wz;
      sum_r[s] += 40'(b.red);
      sum_g[s] += 40'(b.green);
      sum_b[s] += 40'(b.blue);
      sq = half_sq(wx, fx) + half_sq(wy, fy) + half_sq(wz, fz);
      sum_sq[s] += sq >> 2;
      cnt[s] += 32'd1;
      r.status = found ? StUpd : StIns;
      r.slot = 12'(s);
      fill(r, s);
      queue_res(r);
    endfunction

    task report(string msg);
      $display("mismatch: %s", msg);
      errors++;
    endtask

    task field(string name, logic [63:0] got, logic [63:0] want);
      if (got !== want) report($sformatf("%s got %0h want %0h", name, got, want));
    endtask

    task check_beat(out_item_t got);
      out_item_t e;
      if (pending.size() == 0) begin
        report("result beat with nothing expected");
        return;
      end
      e = pending.pop_front();
      field("status", 64'(got.status), 64'(e.status));
      field("slot", 64'(got.slot), 64'(e.slot));
      field("sample_count", 64'(got.sample_count), 64'(e.sample_count));
      field("total_x", got.total_x, e.total_x);
      field("total_y", got.total_y, e.total_y);
      field("total_z", got.total_z, e.total_z);
      field("total_red", 64'(got.total_red), 64'(e.total_red));
      field("total_green", 64'(got.total_green), 64'(e.total_green));
      field("total_blue", 64'(got.total_blue), 64'(e.total_blue));
      field("total_sq_offset", got.total_sq_offset, e.total_sq_offset);
    endtask
  endclass

  localparam int StallLimit = 20000;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        cfg_we_i = 1'b0;
  logic [2:0]  cfg_idx_i = '0;
  logic [22:0] cfg_data_i = '0;
  logic        in_valid_i = 1'b0;
  logic        in_ready_o;
  in_item_t    in_data_i = '0;
  logic        out_valid_o;
  logic        out_ready_i = 1'b0;
  out_item_t   out_data_o;

  voxel_mirror mirror = new();
  int          idle_pct = 0;
  int          stall_pct = 0;
  int          hold_left = 0;
  int          quiet = 0;
  longint      centres [8];

  voxel_grid_accumulator uut (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_idx_i, .cfg_data_i,
    .in_valid_i, .in_ready_o, .in_data_i,
    .out_valid_o, .out_ready_i, .out_data_o
  );

  always #4 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    if (hold_left > 0) begin
      out_ready_i <= 1'b0;
      hold_left <= hold_left - 1;
    end else begin
      out_ready_i <= ($urandom_range(99) >= stall_pct);
    end
  end

  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (out_valid_o && out_ready_i) mirror.check_beat(out_data_o);
      if ((out_valid_o && out_ready_i) || (in_valid_i && in_ready_o)) quiet = 0;
      else quiet++;
      if (quiet >= StallLimit) begin
        $display("watchdog: no beat for %0d cycles", StallLimit);
        $display("tb_voxel_grid_accumulator: errors");
        $finish;
      end
    end
  end

  task write_reg(logic [2:0] idx, logic [22:0] val);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_data_i <= val;
    mirror.set_reg(idx, val);
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  task send_beat(in_item_t b);
    bit acc;
    while ($urandom_range(99) < idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i <= b;
    do begin
      @(negedge clk_i);
      acc = in_ready_o;
      if (acc) mirror.note_beat(b);
      @(posedge clk_i);
    end while (!acc);
  endtask

  task drain();
    in_valid_i <= 1'b0;
    while (mirror.pending.size() != 0) @(posedge clk_i);
    repeat (80) @(posedge clk_i);
  endtask

  task set_regs(int nth, int minr, int maxr, int vox, int inv, int maxv);
    write_reg(CfgNth, 23'(nth));
    write_reg(CfgMinR, 23'(minr));
    write_reg(CfgMaxR, 23'(maxr));
    write_reg(CfgVox, 23'(vox));
    write_reg(CfgInv, 23'(inv));
    write_reg(CfgMaxV, 23'(maxv));
  endtask

  function int pick(int lo, int hi, int typ_lo, int typ_hi);
    int c;
    c = int'($urandom_range(9));
    if (c == 0) return lo;
    if (c == 1) return hi;
    return int'($urandom_range(typ_hi, typ_lo));
  endfunction

  task random_regs();
    set_regs(pick(1, 4095, 1, 4), pick(0, 8388607, 0, 500),
             pick(0, 8388607, 3000, 20000), pick(1, 65535, 1, 65535),
             pick(1, 65536, 16, 4096), pick(1, 4096, 4000, 4096));
    for (int i = 0; i < 8; i++) centres[i] = longint'($signed($urandom()));
  endtask

  function in_item_t point(logic [1:0] kind, longint lx, longint wx, longint wy, longint wz);
    in_item_t b;
    b = '0;
    b.kind = kind;
    b.point_finite = 1'b1;
    b.local_x = 24'(lx);
    b.world_x = 32'(wx);
    b.world_y = 32'(wy);
    b.world_z = 32'(wz);
    b.red = 8'd7;
    b.green = 8'd100;
    b.blue = 8'd200;
    return b;
  endfunction

  function in_item_t rand_beat();
    in_item_t b;
    int       c;
    b = in_item_t'($bits(in_item_t)'({$urandom(), $urandom(), $urandom(), $urandom(),
                                      $urandom(), $urandom(), $urandom()}));
    c = int'($urandom_range(99));
    if (c < 78) b.kind = KindPoint;
    else if (c < 84) b.kind = KindFrame;
    else if (c < 97) b.kind = KindRead;
    else b.kind = KindNone;
    b.point_finite = ($urandom_range(9) != 0);
    if ($urandom_range(4) != 0) begin
      b.local_x = 24'(int'($urandom_range(8191)) - 4096);
      b.local_y = 24'(int'($urandom_range(8191)) - 4096);
      b.local_z = 24'(int'($urandom_range(8191)) - 4096);
    end
    if ($urandom_range(9) < 7) begin
      b.world_x = 32'(centres[$urandom_range(7)] + longint'($urandom_range(2047)) - 1024);
      b.world_y = 32'(centres[$urandom_range(7)] + longint'($urandom_range(2047)) - 1024);
      b.world_z = 32'(centres[$urandom_range(7)] + longint'($urandom_range(2047)) - 1024);
    end
    if ($urandom_range(1) == 0 && mirror.touched.size() != 0)
      b.read_slot = 12'(mirror.touched[$urandom_range(mirror.touched.size() - 1)]);
    return b;
  endfunction

  initial begin
    in_item_t b;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    repeat (4) @(posedge clk_i);

    // default registers: non-finite first point, then a decimated one
    b = point(KindFrame, 0, 0, 0, 0);
    b.point_finite = 1'b0;
    send_beat(b);
    send_beat(point(KindPoint, 0, 0, 0, 0));
    drain();

    set_regs(1, 0, 8388607, 1024, 64, 4096);
    b = point(KindPoint, -8388608, 0, 0, 0);
    b.local_y = 24'sh800000;
    b.local_z = 24'sh800000;
    send_beat(b);
    send_beat(point(KindPoint, 0, 0, 0, 0));
    send_beat(point(KindPoint, 0, 500, 300, 900));
    send_beat(point(KindPoint, 1000, 2147483647, 2147483647, 2147483647));
    send_beat(point(KindPoint, 1000, -2147483647 - 1, -2147483647 - 1, -2147483647 - 1));
    b = point(KindPoint, 8388607, 0, 0, 0);
    b.red = 8'hFF;
    b.green = 8'hFF;
    b.blue = 8'hFF;
    send_beat(b);
    b = '0;
    b.kind = KindRead;
    b.read_slot = 12'(mirror.touched[0]);
    send_beat(b);
    b.read_slot = 12'hFFF;
    send_beat(b);
    b.kind = KindNone;
    send_beat(b);
    send_beat(point(KindFrame, 0, 3000, 0, 0));
    drain();

    // keys that share one hash, past the probe window
    set_regs(1, 0, 8388607, 1, 65536, 4096);
    for (int j = 0; j < 17; j++)
      send_beat(point(KindPoint, 0, longint'((1 << 22) + 4096 * j), 5, 5));
    drain();
    write_reg(CfgMaxV, 23'd1);
    send_beat(point(KindPoint, 0, 777777, 0, 0));
    drain();

    for (int ph = 0; ph < 4; ph++) begin
      idle_pct  = (ph == 1) ? 86 : (ph == 3) ? 32 : 0;
      stall_pct = (ph == 2) ? 86 : (ph == 3) ? 32 : 0;
      if (ph == 0) set_regs(1, 0, 8388607, 300, 218, 4096);
      else random_regs();
      if (ph == 0) for (int i = 0; i < 8; i++) centres[i] = longint'($signed($urandom()));
      for (int i = 0; i < 450; i++) begin
        if (ph == 0 && i == 200) hold_left = 400;
        if (ph == 2 && i == 225) drain();
        send_beat(rand_beat());
      end
      drain();
    end

    if (mirror.pending.size() != 0)
      mirror.report($sformatf("%0d results never arrived", mirror.pending.size()));
    if (mirror.errors == 0) begin
      $display("tb_voxel_grid_accumulator: clean");
    end else begin
      $display("tb_voxel_grid_accumulator: errors");
    end
    $finish;
  end
endmodule
